### rtl/dnsq_pkg.sv
// dnsq_pkg: beat types, register indexes and byte constants for the dns question encoder
// depends on nothing; imported by dns_question_encoder_core and its checker
`timescale 1ns / 1ps

package dnsq_pkg;

  typedef struct packed {
    logic [7:0] name_char;
    logic       is_final_char;
  } name_item_t;

  typedef struct packed {
    logic [8:0] write_offset;
    logic [7:0] write_byte;
    logic       run_end;
    logic [8:0] question_length;
    logic [1:0] error_code;
  } wr_item_t;

  localparam logic [1:0] CFG_QUERY_TYPE   = 2'd0;
  localparam logic [1:0] CFG_QUERY_CLASS  = 2'd1;
  localparam logic [1:0] CFG_EDNS0_ENABLE = 2'd2;

  localparam logic [1:0] ERR_OK         = 2'd0;
  localparam logic [1:0] ERR_LONG_LABEL = 2'd1;
  localparam logic [1:0] ERR_DROPPED    = 2'd2;

  localparam logic [7:0] DOT_CHAR  = 8'h2E;
  localparam logic [7:0] MAX_LABEL = 8'd63;

  // tail write sequence after the final character
  localparam logic [4:0] TAIL_LABEL      = 5'd0;
  localparam logic [4:0] TAIL_TERM       = 5'd1;
  localparam logic [4:0] TAIL_TYPE_HI    = 5'd2;
  localparam logic [4:0] TAIL_TYPE_LO    = 5'd3;
  localparam logic [4:0] TAIL_CLASS_HI   = 5'd4;
  localparam logic [4:0] TAIL_CLASS_LO   = 5'd5;
  localparam logic [4:0] TAIL_OPT_FIRST  = 5'd6;
  localparam logic [4:0] TAIL_LAST_EDNS  = 5'd16;

  localparam logic [8:0] TAIL_LEN_BASE = 9'd6;
  localparam logic [8:0] TAIL_LEN_EDNS = 9'd17;

  // edns0 opt record: 00 00 29 10 00 00 00 00 00 00 00
  function automatic logic [7:0] opt_byte(input logic [3:0] idx);
    logic [7:0] b;
    case (idx)
      4'd2:    b = 8'h29;
      4'd3:    b = 8'h10;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

### rtl/dns_question_encoder_core.sv
// dns_question_encoder_core: streaming qname label encoder with question tail writer
// depends on dnsq_pkg
`timescale 1ns / 1ps

// Takes one name character per beat and answers with addressed byte writes of the
// question section in wire form. A non-final character is taken every cycle unless the
// result register is stalled, and gives one write in the next cycle through that single
// result register. A final character gives 7 writes, or 18 with EDNS0, one per cycle
// from the tail sequencer while the result side does not stall; no character is taken
// while those are emitted. Configuration is read when the tail is emitted.
module dns_question_encoder_core
  import dnsq_pkg::*;
#(
  parameter int MAX_NAME_CHARS = 255
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       name_valid,
  output logic       name_ready,
  input  name_item_t name_item,
  output logic       wr_valid,
  input  logic       wr_ready,
  output wr_item_t   wr_item,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [15:0] cfg_data
);

  logic [15:0] query_type;
  logic [15:0] query_class;
  logic        edns0_enable;
  logic [7:0]  chars_taken;
  logic [7:0]  label_start;
  logic [7:0]  label_length;
  logic        tail_active;
  logic [4:0]  tail_idx;

  logic       out_free;
  logic       name_fire;
  logic       out_load;
  logic       dropped;
  logic       is_dot;
  logic       tail_last;
  logic [1:0] label_err;
  logic [8:0] n9;
  wr_item_t   char_wr;
  wr_item_t   tail_wr;
  wr_item_t   wr_item_next;

  assign out_free   = !wr_valid || wr_ready;
  assign name_ready = !tail_active && out_free;
  assign name_fire  = name_valid && name_ready;
  assign out_load   = out_free && (tail_active || name_fire);

  assign dropped   = chars_taken >= 8'(MAX_NAME_CHARS);
  assign is_dot    = name_item.name_char == DOT_CHAR;
  assign label_err = (label_length > MAX_LABEL) ? ERR_LONG_LABEL : ERR_OK;
  assign n9        = {1'b0, chars_taken};
  assign tail_last = tail_idx == (edns0_enable ? TAIL_LAST_EDNS : TAIL_CLASS_LO);

  // write for the character itself
  always_comb begin
    char_wr = '0;
    if (dropped) begin
      char_wr.write_offset = {1'b0, label_start};
      char_wr.write_byte   = label_length;
      char_wr.error_code   = ERR_DROPPED;
    end else if (is_dot) begin
      char_wr.write_offset = {1'b0, label_start};
      char_wr.write_byte   = label_length;
      char_wr.error_code   = label_err;
    end else begin
      char_wr.write_offset = n9 + 9'd1;
      char_wr.write_byte   = name_item.name_char;
    end
  end

  // tail writes: last label length, terminator, type, class, opt record
  always_comb begin
    tail_wr = '0;
    tail_wr.write_offset = n9 + 9'(tail_idx);
    case (tail_idx)
      TAIL_LABEL: begin
        tail_wr.write_offset = {1'b0, label_start};
        tail_wr.write_byte   = label_length;
        tail_wr.error_code   = label_err;
      end
      TAIL_TERM:     tail_wr.write_byte = 8'h00;
      TAIL_TYPE_HI:  tail_wr.write_byte = query_type[15:8];
      TAIL_TYPE_LO:  tail_wr.write_byte = query_type[7:0];
      TAIL_CLASS_HI: tail_wr.write_byte = query_class[15:8];
      TAIL_CLASS_LO: tail_wr.write_byte = query_class[7:0];
      default:       tail_wr.write_byte = opt_byte(4'(tail_idx - TAIL_OPT_FIRST));
    endcase
    if (tail_last) begin
      tail_wr.run_end         = 1'b1;
      tail_wr.question_length = n9 + (edns0_enable ? TAIL_LEN_EDNS : TAIL_LEN_BASE);
    end
  end

  assign wr_item_next = tail_active ? tail_wr : char_wr;

  always_ff @(posedge clk) begin
    if (out_load) begin
      wr_item <= wr_item_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      query_type   <= 16'd1;
      query_class  <= 16'd1;
      edns0_enable <= 1'b0;
      chars_taken  <= '0;
      label_start  <= '0;
      label_length <= '0;
      tail_active  <= 1'b0;
      tail_idx     <= '0;
      wr_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_QUERY_TYPE:   query_type   <= cfg_data;
          CFG_QUERY_CLASS:  query_class  <= cfg_data;
          CFG_EDNS0_ENABLE: edns0_enable <= cfg_data[0];
          default: ;
        endcase
      end

      if (out_load) begin
        wr_valid <= 1'b1;
      end else if (wr_ready) begin
        wr_valid <= 1'b0;
      end

      if (name_fire) begin
        if (!dropped) begin
          chars_taken <= chars_taken + 8'd1;
          if (is_dot) begin
            label_start  <= chars_taken + 8'd1;
            label_length <= '0;
          end else begin
            label_length <= label_length + 8'd1;
          end
        end
        if (name_item.is_final_char) begin
          tail_active <= 1'b1;
          tail_idx    <= TAIL_LABEL;
        end
      end else if (tail_active && out_free) begin
        if (tail_last) begin
          tail_active  <= 1'b0;
          chars_taken  <= '0;
          label_start  <= '0;
          label_length <= '0;
        end else begin
          tail_idx <= tail_idx + 5'd1;
        end
      end
    end
  end

endmodule

### rtl/dnsq_checker.sv
// dnsq_checker: port-level assertions for dns_question_encoder_core, and its bind
// depends on dnsq_pkg and dns_question_encoder_core
`timescale 1ns / 1ps

module dnsq_checker
  import dnsq_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       name_valid,
  input logic       name_ready,
  input name_item_t name_item,
  input logic       wr_valid,
  input logic       wr_ready,
  input wr_item_t   wr_item
);

  // a stalled result blocks new characters
  assert property (@(posedge clk) disable iff (rst)
    wr_valid && !wr_ready |-> !name_ready)
    else $error("name beat taken while result stalled");

  // every accepted character produces a write in the next cycle
  assert property (@(posedge clk) disable iff (rst)
    name_valid && name_ready |=> wr_valid)
    else $error("no write after accepted name beat");

  // the final character starts the tail, which holds off the next beat
  assert property (@(posedge clk) disable iff (rst)
    name_valid && name_ready && name_item.is_final_char |=> !name_ready)
    else $error("name beat accepted during tail");

  // a question is at least a length byte and one character plus terminator, type and class
  assert property (@(posedge clk) disable iff (rst)
    wr_valid && wr_item.run_end |-> wr_item.question_length >= 9'd7)
    else $error("question length too short");

  // stalled result beat holds
  assert property (@(posedge clk) disable iff (rst)
    wr_valid && !wr_ready |=> wr_valid && $stable(wr_item))
    else $error("result beat changed while stalled");

endmodule

bind dns_question_encoder_core dnsq_checker u_dnsq_checker (
  .clk        (clk),
  .rst        (rst),
  .name_valid (name_valid),
  .name_ready (name_ready),
  .name_item  (name_item),
  .wr_valid   (wr_valid),
  .wr_ready   (wr_ready),
  .wr_item    (wr_item)
);
